/* rtl/irpd_pkg.sv */
// irpd_pkg: shared types, constants and register codes of the ir pulse distance decoder
`timescale 1ns / 1ps

package irpd_pkg;

  // tick counts and thresholds
  localparam int unsigned TickW   = 24;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = 3;

  // bit counter, saturating
  localparam int unsigned CntW   = 6;
  localparam int unsigned CntMax = 63;

  // result word width seen on the port
  localparam int unsigned CodeW = 16;

  // default for the shift word length
  localparam int unsigned WordBitsDefault = 16;

  typedef logic [TickW-1:0]   tick_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [CodeW-1:0]   code_t;
  typedef tick_t [NumRegs-1:0] thresh_t;

  // register indexes
  localparam reg_idx_t RegIdle   = 3'd0;
  localparam reg_idx_t RegRepeat = 3'd1;
  localparam reg_idx_t RegStart  = 3'd2;
  localparam reg_idx_t RegFence  = 3'd3;
  localparam reg_idx_t RegOne    = 3'd4;
  localparam reg_idx_t RegZero   = 3'd5;

  // reset thresholds in 80 MHz ticks
  localparam tick_t IdleGapReset   = 24'd2044000;
  localparam tick_t RepeatGapReset = 24'd1596000;
  localparam tick_t StartGapReset  = 24'd956000;
  localparam tick_t FenceGapReset  = 24'd356000;
  localparam tick_t OneBitReset    = 24'd156000;
  localparam tick_t ZeroBitReset   = 24'd76000;

  // interval classes, longest first
  typedef enum logic [2:0] {
    GapIdle,
    GapRepeat,
    GapStart,
    GapFence,
    GapOne,
    GapZero,
    GapShort
  } gap_class_e;

endpackage

/* rtl/irpd_if.sv */
// irpd_if: valid/ready channel interfaces for input, result and register writes
`timescale 1ns / 1ps

interface irpd_in_if;
  logic                valid;
  logic                ready;
  irpd_pkg::tick_t     edge_interval;

  modport source (output valid, output edge_interval, input ready);
  modport sink   (input valid, input edge_interval, output ready);
endinterface

interface irpd_out_if;
  logic                valid;
  logic                ready;
  irpd_pkg::code_t     code_word;
  logic                frame_ready;

  modport source (output valid, output code_word, output frame_ready, input ready);
  modport sink   (input valid, input code_word, input frame_ready, output ready);
endinterface

interface irpd_cfg_if;
  logic                valid;
  logic                ready;
  irpd_pkg::reg_idx_t index;
  irpd_pkg::tick_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/irpd_classify.sv */
// irpd_classify: priority compare of one interval against the six thresholds
`timescale 1ns / 1ps

module irpd_classify (
  input  irpd_pkg::tick_t      interval_i,
  input  irpd_pkg::thresh_t    thresh_i,
  output irpd_pkg::gap_class_e class_o
);

  // fixed priority order, first strict compare that holds wins
  always_comb begin
    if (interval_i > thresh_i[irpd_pkg::RegIdle]) begin
      class_o = irpd_pkg::GapIdle;
    end else if (interval_i > thresh_i[irpd_pkg::RegRepeat]) begin
      class_o = irpd_pkg::GapRepeat;
    end else if (interval_i > thresh_i[irpd_pkg::RegStart]) begin
      class_o = irpd_pkg::GapStart;
    end else if (interval_i > thresh_i[irpd_pkg::RegFence]) begin
      class_o = irpd_pkg::GapFence;
    end else if (interval_i > thresh_i[irpd_pkg::RegOne]) begin
      class_o = irpd_pkg::GapOne;
    end else if (interval_i > thresh_i[irpd_pkg::RegZero]) begin
      class_o = irpd_pkg::GapZero;
    end else begin
      class_o = irpd_pkg::GapShort;
    end
  end

endmodule

/* rtl/ir_pulse_distance_decoder.sv */
// ir_pulse_distance_decoder: top level of the pulse distance ir remote decoder
// path: an accepted interval is registered in the input register, then in the result register,
// where its result is valid; it waits in the input register while the result register stalls
// throughput: one interval per cycle while out ready is high, set by the single compare-and-shift pass
// the input register can fill while a finished result waits, but then holds its item until it is taken
// reset: thresholds return to their defaults, word, bit count and skip flag clear,
// both pipeline stages empty
`timescale 1ns / 1ps

module ir_pulse_distance_decoder #(
  parameter int unsigned WORD_BITS = irpd_pkg::WordBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  irpd_cfg_if.sink          cfg_i,
  irpd_in_if.sink           in_i,
  irpd_out_if.source        out_o
);

  // threshold registers
  irpd_pkg::thresh_t thresh_q;

  // input stage
  logic              s1_valid_q;
  irpd_pkg::tick_t   s1_interval_q;

  // decoder state
  logic [WORD_BITS-1:0] word_q, word_d;
  irpd_pkg::cnt_t       cnt_q, cnt_d;
  logic                 skip_q, skip_d;

  // result stage
  logic              res_valid_q;
  irpd_pkg::code_t   res_code_q;
  logic              res_frame_q;
  logic              frame_d;

  logic              res_load;
  irpd_pkg::gap_class_e gap_class;

  localparam irpd_pkg::cnt_t FrameCnt = irpd_pkg::CntW'(WORD_BITS);
  localparam irpd_pkg::cnt_t CntSat   = irpd_pkg::CntW'(irpd_pkg::CntMax);

  // register writes are always taken, out of range indexes dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q[irpd_pkg::RegIdle]   <= irpd_pkg::IdleGapReset;
      thresh_q[irpd_pkg::RegRepeat] <= irpd_pkg::RepeatGapReset;
      thresh_q[irpd_pkg::RegStart]  <= irpd_pkg::StartGapReset;
      thresh_q[irpd_pkg::RegFence]  <= irpd_pkg::FenceGapReset;
      thresh_q[irpd_pkg::RegOne]    <= irpd_pkg::OneBitReset;
      thresh_q[irpd_pkg::RegZero]   <= irpd_pkg::ZeroBitReset;
    end else if (cfg_i.valid && (cfg_i.index < irpd_pkg::RegIdxW'(irpd_pkg::NumRegs))) begin
      thresh_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // result register moves when empty or when its transfer completes
  assign res_load   = s1_valid_q && (!res_valid_q || out_o.ready);
  // input register refills when empty or whenever its item moves on
  assign in_i.ready = !s1_valid_q || res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_interval_q <= in_i.edge_interval;
    end
  end

  irpd_classify u_classify (
    .interval_i (s1_interval_q),
    .thresh_i   (thresh_q),
    .class_o    (gap_class)
  );

  // state update for the item in the input register
  always_comb begin
    word_d  = word_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    frame_d = 1'b0;
    case (gap_class)
      irpd_pkg::GapIdle, irpd_pkg::GapStart: begin
        word_d = '0;
        cnt_d  = '0;
      end
      irpd_pkg::GapRepeat: begin
        // repeat code: drop the word and suppress the next frame
        word_d = '0;
        cnt_d  = '0;
        skip_d = 1'b1;
      end
      irpd_pkg::GapOne: begin
        word_d = {1'b1, word_q[WORD_BITS-1:1]};
        cnt_d  = (cnt_q == CntSat) ? cnt_q : cnt_q + 1'b1;
      end
      irpd_pkg::GapZero: begin
        word_d = {1'b0, word_q[WORD_BITS-1:1]};
        cnt_d  = (cnt_q == CntSat) ? cnt_q : cnt_q + 1'b1;
      end
      default: begin
        // fence gap or too short: no change
      end
    endcase
    // ready check runs on every item, even when nothing shifted
    if (cnt_d == FrameCnt) begin
      frame_d = !skip_d;
      skip_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      cnt_q  <= '0;
      skip_q <= 1'b0;
    end else if (res_load) begin
      word_q <= word_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // low word bits go out, zero filled for short words
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_code_q  <= irpd_pkg::CodeW'(word_d);
      res_frame_q <= frame_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.code_word   = res_code_q;
  assign out_o.frame_ready = res_frame_q;

endmodule
